FILE: rtl/core/bgs_pkg.sv
`timescale 1ns / 1ps
package bgs_pkg;

  localparam int MAX_X_DEF      = 32;
  localparam int MAX_Y_DEF      = 32;
  localparam int VALUE_BITS_DEF = 16;
  localparam int IO_BITS        = 16;
  localparam int CFG_AW         = 5;
  localparam int CFG_DW         = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_X_SIZE = 3'd0,
    REG_Y_SIZE = 3'd1,
    REG_CX     = 3'd2,
    REG_CY     = 3'd3,
    REG_STEPS  = 3'd4
  } reg_t;

  localparam logic [5:0]  X_SIZE_RST = 6'd32;
  localparam logic [5:0]  Y_SIZE_RST = 6'd32;
  localparam logic [15:0] CX_RST     = 16'd1638;
  localparam logic [15:0] CY_RST     = 16'd1638;
  localparam logic [15:0] STEPS_RST  = 16'd1;

  typedef struct packed {
    logic [5:0]  x_size;
    logic [5:0]  y_size;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] steps;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RD_C,
    ST_RD_W,
    ST_RD_N,
    ST_MUL_A,
    ST_RND_A,
    ST_MUL_U,
    ST_MUL_V,
    ST_WR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic lat_c;
    logic lat_w;
    logic lat_n;
    logic mul_a;
    logic rnd_a;
    logic mul_u;
    logic mul_v;
  } upd_ctl_t;

endpackage

FILE: rtl/core/bgs_if.sv
`timescale 1ns / 1ps
interface bgs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [4:0]         x_index;
  logic [4:0]         y_index;
  logic signed [15:0] u_in;
  logic signed [15:0] v_in;

  modport source(output valid, opcode, x_index, y_index, u_in, v_in, input ready);
  modport sink(input valid, opcode, x_index, y_index, u_in, v_in, output ready);
endinterface

interface bgs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         done_kind;
  logic signed [15:0] u_out;
  logic signed [15:0] v_out;

  modport source(output valid, done_kind, u_out, v_out, input ready);
  modport sink(input valid, done_kind, u_out, v_out, output ready);
endinterface

FILE: rtl/core/burgers_2d_upwind_stencil.sv
`timescale 1ns / 1ps
// 2D upwind advection stencil on two velocity grids u and v (signed, FRAC = VALUE_BITS-4).
// Input channel in_ch carries one command per transfer: write cell, run steps, read cell.
// Output channel out_ch returns exactly one result per command: done_kind echoes the
// opcode, u_out/v_out hold the cell for a read and zero otherwise.
// Write and unused opcode answer in the cycle after the input transfer; a read answers
// through ST_READ and then the output register. A run visits all MAX_X * MAX_Y cells
// per step, used or not, each through RD_C, RD_W, RD_N, MUL_A, RND_A, MUL_U, MUL_V, WR,
// set by the single read port of the grid memory (center, west, north) plus the multiplies.
// One command is in flight at a time; a new command is taken once the output register
// is empty or being drained in the same cycle, so a stalled receiver holds the block.
// Grids live in one memory of 2 banks x MAX_X*MAX_Y words of {u,v}; a step reads one
// bank and writes the other, then flips the bank select.
// Reset (rst_n low, sync) clears control, bank select and APB registers to their defaults;
// the grid memory is not cleared, every cell must be written before use.
// APB registers at 4*i: x_size, y_size, courant_x, courant_y, step_count.
module burgers_2d_upwind_stencil import bgs_pkg::*; #(
  parameter int MAX_X      = MAX_X_DEF,
  parameter int MAX_Y      = MAX_Y_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  bgs_in_if.sink            in_ch,
  bgs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int VB    = VALUE_BITS;
  localparam int FRAC  = VB - 4;
  localparam int CELLS = MAX_X * MAX_Y;
  localparam int DEPTH = 2 * CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = $clog2(MAX_Y);
  localparam int XSW   = $clog2(MAX_X + 1);
  localparam int YSW   = $clog2(MAX_Y + 1);
  localparam int EW    = ((VB > IO_BITS) ? VB : IO_BITS) + 1;
  localparam logic signed [EW-1:0] VHI = (EW'(1) <<< (VB - 1)) - EW'(1);
  localparam logic signed [EW-1:0] VLO = -VHI - EW'(1);
  localparam logic signed [EW-1:0] OHI = (EW'(1) <<< (IO_BITS - 1)) - EW'(1);
  localparam logic signed [EW-1:0] OLO = -OHI - EW'(1);
  localparam logic [VB-1:0] ONE = VB'(1) << FRAC;

  cfg_t     cfg;
  upd_ctl_t ctl;
  state_t   state_r, state_nxt;

  logic            bank_r, bank_nxt;
  logic [XW-1:0]   x_r, x_nxt;
  logic [YW-1:0]   y_r, y_nxt;
  logic [XSW-1:0]  xs_r, xs_nxt;
  logic [YSW-1:0]  ys_r, ys_nxt;
  logic [15:0]     steps_r, steps_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_kind_r, out_kind_nxt;
  logic [15:0]     out_u_r, out_u_nxt, out_v_r, out_v_nxt;

  logic            acc, host_in, last_cell, cell_copy, cell_edge;
  logic            we;
  logic [AW-1:0]   waddr, raddr, src_off, dst_off, cell_i, host_i, c_addr;
  logic [2*VB-1:0] wdata, rdata, cur_word, new_word;
  op_t             op;

  function automatic logic [VB-1:0] sat_in(input logic signed [IO_BITS-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    e = (e > VHI) ? VHI : ((e < VLO) ? VLO : e);
    return e[VB-1:0];
  endfunction

  function automatic logic [IO_BITS-1:0] sat_out(input logic signed [VB-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    e = (e > OHI) ? OHI : ((e < OLO) ? OLO : e);
    return e[IO_BITS-1:0];
  endfunction

  bgs_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bgs_mem #(.DW(2 * VB), .DEPTH(DEPTH)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  bgs_upd #(.VB(VB)) u_upd (
    .clk, .ctl, .rdata, .cx(cfg.cx), .cy(cfg.cy), .cur_word, .new_word
  );

  assign op        = op_t'(in_ch.opcode);
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign acc       = in_ch.valid && in_ch.ready;
  assign host_in   = (int'(in_ch.x_index) < MAX_X) && (int'(in_ch.y_index) < MAX_Y);

  // bank offsets, cell index in row-major order (y fastest)
  assign src_off = bank_r ? AW'(CELLS) : '0;
  assign dst_off = bank_r ? '0 : AW'(CELLS);
  assign cell_i  = AW'(x_r) * AW'(MAX_Y) + AW'(y_r);
  assign host_i  = AW'(in_ch.x_index) * AW'(MAX_Y) + AW'(in_ch.y_index);
  assign c_addr  = src_off + cell_i;

  assign last_cell = (int'(x_r) == MAX_X - 1) && (int'(y_r) == MAX_Y - 1);
  // corner at origin and cells beyond the used region are carried over
  assign cell_copy = (XSW'(x_r) >= xs_r) || (YSW'(y_r) >= ys_r) || (x_r == '0 && y_r == '0);
  assign cell_edge = (x_r == '0) || (y_r == '0) ||
                     (XSW'(x_r) == xs_r - XSW'(1)) || (YSW'(y_r) == ys_r - YSW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (op)
            OP_READ: state_nxt = ST_READ;
            OP_RUN:  state_nxt = (cfg.steps == '0) ? ST_FIN : ST_RD_C;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_nxt = ST_IDLE;
      ST_RD_C:  state_nxt = ST_RD_W;
      ST_RD_W:  state_nxt = ST_RD_N;
      ST_RD_N:  state_nxt = ST_MUL_A;
      ST_MUL_A: state_nxt = ST_RND_A;
      ST_RND_A: state_nxt = ST_MUL_U;
      ST_MUL_U: state_nxt = ST_MUL_V;
      ST_MUL_V: state_nxt = ST_WR;
      ST_WR:    state_nxt = (last_cell && steps_r == 16'd1) ? ST_FIN : ST_RD_C;
      ST_FIN:   state_nxt = (!out_valid_r || out_ch.ready) ? ST_IDLE : ST_FIN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctl           = '0;
    we            = 1'b0;
    waddr         = dst_off + cell_i;
    wdata         = new_word;
    raddr         = src_off + host_i;
    bank_nxt      = bank_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    xs_nxt        = xs_r;
    ys_nxt        = ys_r;
    steps_nxt     = steps_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_u_nxt     = out_u_r;
    out_v_nxt     = out_v_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (op)
            OP_WRITE: begin
              we            = host_in;
              waddr         = src_off + host_i;
              wdata         = {sat_in(in_ch.u_in), sat_in(in_ch.v_in)};
              out_valid_nxt = 1'b1;
              out_kind_nxt  = OP_WRITE;
              out_u_nxt     = '0;
              out_v_nxt     = '0;
            end
            OP_READ: rd_ok_nxt = host_in;
            OP_RUN: begin
              x_nxt     = '0;
              y_nxt     = '0;
              steps_nxt = cfg.steps;
              xs_nxt    = XSW'((int'(cfg.x_size) < 3) ? 3 :
                               ((int'(cfg.x_size) > MAX_X) ? MAX_X : int'(cfg.x_size)));
              ys_nxt    = YSW'((int'(cfg.y_size) < 3) ? 3 :
                               ((int'(cfg.y_size) > MAX_Y) ? MAX_Y : int'(cfg.y_size)));
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = in_ch.opcode;
              out_u_nxt     = '0;
              out_v_nxt     = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = OP_READ;
        out_u_nxt     = rd_ok_r ? sat_out(rdata[2*VB-1:VB]) : '0;
        out_v_nxt     = rd_ok_r ? sat_out(rdata[VB-1:0]) : '0;
      end
      ST_RD_C: raddr = c_addr;
      ST_RD_W: begin
        raddr     = c_addr - AW'(MAX_Y);
        ctl.lat_c = 1'b1;
      end
      ST_RD_N: begin
        raddr     = c_addr - AW'(1);
        ctl.lat_w = 1'b1;
      end
      ST_MUL_A: begin
        ctl.lat_n = 1'b1;
        ctl.mul_a = 1'b1;
      end
      ST_RND_A: ctl.rnd_a = 1'b1;
      ST_MUL_U: ctl.mul_u = 1'b1;
      ST_MUL_V: ctl.mul_v = 1'b1;
      ST_WR: begin
        we    = 1'b1;
        wdata = cell_copy ? cur_word : (cell_edge ? {ONE, ONE} : new_word);
        if (int'(y_r) == MAX_Y - 1) begin
          y_nxt = '0;
          x_nxt = last_cell ? '0 : x_r + XW'(1);
        end else begin
          y_nxt = y_r + YW'(1);
        end
        if (last_cell) begin
          bank_nxt  = ~bank_r;
          steps_nxt = steps_r - 16'd1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = OP_RUN;
          out_u_nxt     = '0;
          out_v_nxt     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      y_r         <= '0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xs_r       <= xs_nxt;
    ys_r       <= ys_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_kind_r <= out_kind_nxt;
    out_u_r    <= out_u_nxt;
    out_v_r    <= out_v_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.done_kind = out_kind_r;
  assign out_ch.u_out     = out_u_r;
  assign out_ch.v_out     = out_v_r;

endmodule

FILE: rtl/core/bgs_cfg.sv
`timescale 1ns / 1ps
module bgs_cfg import bgs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_X_SIZE: cfg_nxt.x_size = pwdata[5:0];
        REG_Y_SIZE: cfg_nxt.y_size = pwdata[5:0];
        REG_CX:     cfg_nxt.cx     = pwdata[15:0];
        REG_CY:     cfg_nxt.cy     = pwdata[15:0];
        REG_STEPS:  cfg_nxt.steps  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_SIZE: prdata = {26'd0, cfg_r.x_size};
      REG_Y_SIZE: prdata = {26'd0, cfg_r.y_size};
      REG_CX:     prdata = {16'd0, cfg_r.cx};
      REG_CY:     prdata = {16'd0, cfg_r.cy};
      REG_STEPS:  prdata = {16'd0, cfg_r.steps};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{x_size: X_SIZE_RST, y_size: Y_SIZE_RST, cx: CX_RST, cy: CY_RST,
                 steps: STEPS_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/bgs_mem.sv
`timescale 1ns / 1ps
module bgs_mem #(
  parameter int  DW    = 32,
  parameter int  DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bgs_upd.sv
`timescale 1ns / 1ps
module bgs_upd import bgs_pkg::*; #(
  parameter int VB = VALUE_BITS_DEF
) (
  input  logic              clk,
  input  upd_ctl_t          ctl,
  input  logic [2*VB-1:0]   rdata,
  input  logic [15:0]       cx,
  input  logic [15:0]       cy,
  output logic [2*VB-1:0]   cur_word,
  output logic [2*VB-1:0]   new_word
);

  localparam int FRAC = VB - 4;
  localparam int PA   = VB + 17;
  localparam int DW   = VB + 1;
  localparam int PT   = 2 * VB + 2;
  localparam int SW   = PT + 2;
  localparam logic signed [PA-1:0] HALF_A = PA'(32'sd32768);
  localparam logic signed [PT-1:0] HALF_T = PT'(1) <<< (FRAC - 1);
  localparam logic signed [SW-1:0] HI     = (SW'(1) <<< (VB - 1)) - SW'(1);
  localparam logic signed [SW-1:0] LO     = -HI - SW'(1);

  logic signed [VB-1:0] uc_r, vc_r, uw_r, vw_r, un_r, vn_r;
  logic signed [PA-1:0] pa_x_r, pa_y_r;
  logic signed [DW-1:0] ax_r, ay_r;
  logic signed [PT-1:0] pux_r, puy_r, pvx_r, pvy_r;
  logic signed [DW-1:0] du_w, du_n, dv_w, dv_n;
  logic signed [SW-1:0] su, sv;

  function automatic logic [VB-1:0] sat_v(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] y;
    y = (x > HI) ? HI : ((x < LO) ? LO : x);
    return y[VB-1:0];
  endfunction

  function automatic logic signed [SW-1:0] rnd_t(input logic signed [PT-1:0] p);
    logic signed [PT-1:0] q;
    q = (p + HALF_T) >>> FRAC;
    return SW'(q);
  endfunction

  assign du_w = DW'(uc_r) - DW'(uw_r);
  assign du_n = DW'(uc_r) - DW'(un_r);
  assign dv_w = DW'(vc_r) - DW'(vw_r);
  assign dv_n = DW'(vc_r) - DW'(vn_r);

  always_ff @(posedge clk) begin
    if (ctl.lat_c) {uc_r, vc_r} <= rdata;
    if (ctl.lat_w) {uw_r, vw_r} <= rdata;
    if (ctl.lat_n) {un_r, vn_r} <= rdata;
    if (ctl.mul_a) begin
      pa_x_r <= PA'(uc_r) * PA'($signed({1'b0, cx}));
      pa_y_r <= PA'(vc_r) * PA'($signed({1'b0, cy}));
    end
    if (ctl.rnd_a) begin
      ax_r <= DW'((pa_x_r + HALF_A) >>> 16);
      ay_r <= DW'((pa_y_r + HALF_A) >>> 16);
    end
    if (ctl.mul_u) begin
      pux_r <= PT'(ax_r) * PT'(du_w);
      puy_r <= PT'(ay_r) * PT'(du_n);
    end
    if (ctl.mul_v) begin
      pvx_r <= PT'(ax_r) * PT'(dv_w);
      pvy_r <= PT'(ay_r) * PT'(dv_n);
    end
  end

  assign su       = SW'(uc_r) - rnd_t(pux_r) - rnd_t(puy_r);
  assign sv       = SW'(vc_r) - rnd_t(pvx_r) - rnd_t(pvy_r);
  assign new_word = {sat_v(su), sat_v(sv)};
  assign cur_word = {uc_r, vc_r};

endmodule

FILE: rtl/core/bgs_chk.sv
`timescale 1ns / 1ps
module bgs_chk import bgs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !(out_valid && !out_ready))
    else $error("command taken while result blocked");

  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_WRITE |=> out_valid && out_kind == OP_WRITE)
    else $error("write not acknowledged next cycle");

  a_read_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_READ |=> ##1 out_valid && out_kind == OP_READ)
    else $error("read result late");

endmodule

bind burgers_2d_upwind_stencil bgs_chk u_bgs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.done_kind)
);

FILE: tb/tb_burgers_2d_upwind_stencil.sv
`timescale 1ns / 1ps
module tb_burgers_2d_upwind_stencil;
  import bgs_pkg::*;

  localparam int GX = MAX_X_DEF;
  localparam int GY = MAX_Y_DEF;
  localparam int CELLS = GX * GY;
  localparam int FRAC = VALUE_BITS_DEF - 4;

  // one command on the input channel
  typedef struct {
    op_t                op;
    logic [4:0]         xi;
    logic [4:0]         yi;
    logic signed [15:0] u;
    logic signed [15:0] v;
  } cmd_t;

  // one answer on the result channel
  typedef struct {
    op_t                kind;
    logic signed [15:0] u;
    logic signed [15:0] v;
  } ans_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  bgs_in_if  in_if();
  bgs_out_if out_if();

  burgers_2d_upwind_stencil DUT (
    .clk(clk), .rst_n(rst_n),
    .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the block: two banks per grid plus the live register values.
  // ---------------------------------------------------------------------------
  logic signed [15:0] u_mem [2][CELLS];
  logic signed [15:0] v_mem [2][CELLS];
  bit          bank;
  logic [5:0]  sh_xs, sh_ys;
  logic [15:0] sh_cx, sh_cy, sh_steps;

  cmd_t cmd_q[$];      // commands waiting for the driver
  ans_t answer_q[$];   // answers still owed by the block
  int   errors;
  bit   no_idle;       // stretch with no gaps on either side
  bit   rx_hold_arm;   // asks the receiver for one long stall

  // add one half, then floor (arithmetic shift floors on signed values)
  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic logic signed [15:0] upwind(longint c, longint w, longint n,
                                                longint ax, longint ay);
    longint tx, ty;
    tx = rnd_shift(ax * (c - w), FRAC);
    ty = rnd_shift(ay * (c - n), FRAC);
    return sat16(c - tx - ty);
  endfunction

  // one time step over the whole grid, reading bank 'bank' and writing the other
  task automatic grid_step(int xs, int ys);
    int src, dst, i;
    longint uc, vc, ax, ay;
    src = int'(bank);
    dst = int'(!bank);
    for (int x = 0; x < GX; x++) begin
      for (int y = 0; y < GY; y++) begin
        i = x * GY + y;
        uc = u_mem[src][i];
        vc = v_mem[src][i];
        if (x >= xs || y >= ys || (x == 0 && y == 0)) begin
          u_mem[dst][i] = u_mem[src][i];
          v_mem[dst][i] = v_mem[src][i];
        end else if (x == 0 || y == 0 || x == xs - 1 || y == ys - 1) begin
          u_mem[dst][i] = 16'sd1 <<< FRAC;
          v_mem[dst][i] = 16'sd1 <<< FRAC;
        end else begin
          ax = rnd_shift(uc * longint'(sh_cx), 16);
          ay = rnd_shift(vc * longint'(sh_cy), 16);
          u_mem[dst][i] = upwind(uc, u_mem[src][i-GY], u_mem[src][i-1], ax, ay);
          v_mem[dst][i] = upwind(vc, v_mem[src][i-GY], v_mem[src][i-1], ax, ay);
        end
      end
    end
    bank = ~bank;
  endtask

  // works out the answer of one command and updates the shadow
  task automatic apply_cmd(cmd_t c, output ans_t a);
    int idx, xs, ys;
    idx = c.xi * GY + c.yi;
    a.kind = c.op;
    a.u = '0;
    a.v = '0;
    case (c.op)
      OP_WRITE: begin
        u_mem[bank][idx] = c.u;
        v_mem[bank][idx] = c.v;
      end
      OP_RUN: begin
        xs = sh_xs < 3 ? 3 : (sh_xs > GX ? GX : sh_xs);
        ys = sh_ys < 3 ? 3 : (sh_ys > GY ? GY : sh_ys);
        for (int t = 0; t < sh_steps; t++) grid_step(xs, ys);
      end
      OP_READ: begin
        a.u = u_mem[bank][idx];
        a.v = v_mem[bank][idx];
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers commands from cmd_q with random gaps, changes at negedge.
  // ---------------------------------------------------------------------------
  bit in_took;   // transfer seen at the last rising edge
  int tx_gap;

  always @(negedge clk) begin
    cmd_t c;
    logic nv;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      nv = 1'b0;
      if (in_if.valid && !in_took) begin
        nv = 1'b1;               // still offering the same command
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_if.opcode  <= c.op;
        in_if.x_index <= c.xi;
        in_if.y_index <= c.yi;
        in_if.u_in    <= c.u;
        in_if.v_in    <= c.v;
        nv = 1'b1;
        tx_gap = no_idle ? 0 : $urandom_range(0, 16);
      end
      in_if.valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per result, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  int rx_stall;
  int rx_hold_cnt;
  bit rx_hold_done;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold_arm && !rx_hold_done) begin
      // long stall so the block fills up and pushes back on the sender;
      // only cycles with a result waiting count
      if (out_if.valid) rx_hold_cnt++;
      if (rx_hold_cnt >= 400) rx_hold_done = 1'b1;
      out_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: predict on input transfer, check on output.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_t c;
    ans_t a, got;
    in_took = rst_n && in_if.valid && in_if.ready;
    if (in_took) begin
      c.op = op_t'(in_if.opcode);
      c.xi = in_if.x_index;
      c.yi = in_if.y_index;
      c.u  = in_if.u_in;
      c.v  = in_if.v_in;
      apply_cmd(c, a);
      answer_q.insert(answer_q.size(), a);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      rx_stall = no_idle ? 0 : $urandom_range(0, 16);
      got.kind = op_t'(out_if.done_kind);
      got.u = out_if.u_out;
      got.v = out_if.v_out;
      if (answer_q.size() == 0) begin
        $display("%0t: result with nothing expected: kind %0d u %h v %h",
                 $realtime, got.kind, got.u, got.v);
        errors++;
      end else begin
        a = answer_q.pop_front();
        if (got.kind !== a.kind) begin
          $display("%0t: done_kind expected %0d actual %0d", $realtime, a.kind, got.kind);
          errors++;
        end
        if (got.u !== a.u) begin
          $display("%0t: u_out expected %h actual %h", $realtime, a.u, got.u);
          errors++;
        end
        if (got.v !== a.v) begin
          $display("%0t: v_out expected %h actual %h", $realtime, a.v, got.v);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // append one command behind those already waiting
  task automatic queue_cmd(cmd_t c);
    cmd_q.insert(cmd_q.size(), c);
  endtask

  // APB write: setup cycle, then access cycle; shadow follows the same decode
  task automatic cfg_write(reg_t r, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_X_SIZE: sh_xs    = val[5:0];
      REG_Y_SIZE: sh_ys    = val[5:0];
      REG_CX:     sh_cx    = val[15:0];
      REG_CY:     sh_cy    = val[15:0];
      REG_STEPS:  sh_steps = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_all(int xs, int ys, int cx, int cy, int st);
    cfg_write(REG_X_SIZE, xs);
    cfg_write(REG_Y_SIZE, ys);
    cfg_write(REG_CX, cx);
    cfg_write(REG_CY, cy);
    cfg_write(REG_STEPS, st);
  endtask

  // waits until the sender is empty and every answer is in, then a short settle
  task automatic drain();
    while (cmd_q.size() > 0 || in_if.valid || answer_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_val();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh1000;
      3: return 16'sh0000;
      4: return 16'($urandom_range(0, 16'h2000) - 16'h1000);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic cmd_t mk(op_t op, int x, int y, logic signed [15:0] u,
                              logic signed [15:0] v);
    cmd_t c;
    c.op = op;
    c.xi = 5'(x);
    c.yi = 5'(y);
    c.u  = u;
    c.v  = v;
    return c;
  endfunction

  // mostly reads and writes, an occasional run and a few unused opcodes
  function automatic cmd_t rand_cmd();
    int r;
    op_t op;
    r = $urandom_range(0, 99);
    op = r < 45 ? OP_WRITE : r < 88 ? OP_READ : r < 95 ? OP_RUN : OP_NONE;
    return mk(op, $urandom_range(0, 31), $urandom_range(0, 31), pick_val(), pick_val());
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) queue_cmd(rand_cmd());
    drain();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_NONE;
    in_if.x_index = '0;
    in_if.y_index = '0;
    in_if.u_in = '0;
    in_if.v_in = '0;
    out_if.ready = 1'b0;
    errors = 0;
    no_idle = 1'b0;
    rx_hold_arm = 1'b0;
    rx_stall = 0;
    bank = 1'b0;
    sh_xs = X_SIZE_RST;
    sh_ys = Y_SIZE_RST;
    sh_cx = CX_RST;
    sh_cy = CY_RST;
    sh_steps = STEPS_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every cell written before any read or step touches it; fill back to back
    no_idle = 1'b1;
    for (int x = 0; x < GX; x++)
      for (int y = 0; y < GY; y++)
        queue_cmd(mk(OP_WRITE, x, y, pick_val(), pick_val()));
    drain();
    no_idle = 1'b0;

    // directed: field extremes, each opcode, edge and corner cells, defaults
    queue_cmd(mk(OP_WRITE, 0, 0, 16'sh7fff, 16'sh8000));
    queue_cmd(mk(OP_WRITE, 31, 31, 16'sh8000, 16'sh7fff));
    queue_cmd(mk(OP_WRITE, 5, 5, 16'sh7fff, 16'sh7fff));
    queue_cmd(mk(OP_WRITE, 6, 6, 16'sh8000, 16'sh8000));
    queue_cmd(mk(OP_READ, 0, 0, 16'sh0000, 16'shffff));
    queue_cmd(mk(OP_READ, 31, 31, 16'shffff, 16'sh0000));
    queue_cmd(mk(OP_NONE, 31, 0, 16'sh7fff, 16'sh8000));
    queue_cmd(mk(OP_RUN, 0, 31, 16'sh0000, 16'sh0000));
    queue_cmd(mk(OP_READ, 0, 0, 0, 0));       // corner keeps its value
    queue_cmd(mk(OP_READ, 0, 7, 0, 0));       // edge forced to one
    queue_cmd(mk(OP_READ, 31, 7, 0, 0));
    queue_cmd(mk(OP_READ, 7, 31, 0, 0));
    queue_cmd(mk(OP_READ, 5, 5, 0, 0));
    queue_cmd(mk(OP_READ, 6, 6, 0, 0));
    queue_cmd(mk(OP_READ, 1, 1, 0, 0));
    drain();

    // smallest grid, zero courant, zero steps: run changes nothing
    cfg_all(3, 3, 0, 0, 0);
    queue_cmd(mk(OP_RUN, 0, 0, 0, 0));
    queue_cmd(mk(OP_READ, 1, 1, 0, 0));
    random_phase(40);

    // largest courant numbers drive saturation; unknown register address too
    cfg_all(32, 32, 65535, 65535, 65535);
    cfg_write(reg_t'(3'd5), 32'hffff_ffff);
    cfg_write(REG_STEPS, 1);
    random_phase(45);

    // sizes below and above range get clamped
    cfg_all(0, 63, 1638, 40000, 2);
    random_phase(45);
    cfg_all(33, 2, $urandom_range(0, 65535), $urandom_range(0, 65535), 1);
    random_phase(45);

    // long receiver stall while the sender keeps offering
    cfg_all(17, 5, $urandom_range(0, 65535), $urandom_range(0, 65535), 1);
    rx_hold_arm = 1'b1;
    no_idle = 1'b1;
    random_phase(50);
    no_idle = 1'b0;

    cfg_all($urandom_range(3, 32), $urandom_range(3, 32), 8000, 3000, 1);
    random_phase(60);
    cfg_all(1, 1, $urandom_range(0, 65535), $urandom_range(0, 65535), 1);
    random_phase(50);
    cfg_all(32, 32, CX_RST, CY_RST, 2);
    random_phase(60);

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run budget: covers the slow case, taken several times, then ends as a failure
  initial begin
    #60ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
